>>> rtl/core/ghs_pkg.sv
package ghs_pkg;

    // Input word: one stream event
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] in_byte;
    } in_word_t;

    // Output word: one header report
    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  flag_bits;
        logic [31:0] member_offset;
        logic [31:0] header_end_offset;
    } out_word_t;

    // Result of one parse step
    typedef struct packed {
        logic      valid;
        out_word_t word;
    } res_t;

    // Event codes
    localparam logic [1:0] FUNC_DATA     = 2'd0;
    localparam logic [1:0] FUNC_END      = 2'd1;
    localparam logic [1:0] FUNC_BODY_OK  = 2'd2;
    localparam logic [1:0] FUNC_BODY_BAD = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_METH  = 3'd2;
    localparam logic [2:0] ST_RESERVED  = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    // Header constants
    localparam logic [7:0] MAGIC_A       = 8'h1f;
    localparam logic [7:0] MAGIC_B       = 8'h8b;
    localparam logic [7:0] RES_BITS      = 8'he0;
    localparam logic [4:0] FL_EXTRA      = 5'h04;
    localparam logic [4:0] FL_NAME       = 5'h08;
    localparam logic [4:0] FL_COMMENT    = 5'h10;
    localparam logic [4:0] FL_HCRC       = 5'h02;
    localparam logic [2:0] SKIP_LEN      = 3'd6;
    localparam logic [7:0] METHOD_RESET  = 8'd8;

    // Optional-field levels
    localparam logic [1:0] LVL_EXTRA   = 2'd0;
    localparam logic [1:0] LVL_NAME    = 2'd1;
    localparam logic [1:0] LVL_COMMENT = 2'd2;
    localparam logic [1:0] LVL_HCRC    = 2'd3;

endpackage

>>> rtl/core/ghs_in_stage.sv
module ghs_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ghs_pkg::in_word_t in_data,
    input  logic              advance,
    output logic              word_valid,
    output ghs_pkg::in_word_t word
);
    import ghs_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     take;

    // Hold the word while the parser cannot advance
    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= in_data;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

>>> rtl/core/ghs_parser.sv
module ghs_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  ghs_pkg::in_word_t word,
    input  logic [7:0]        method,
    output ghs_pkg::res_t     res
);
    import ghs_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT, PH_M1, PH_M2, PH_METHOD, PH_FLAGS, PH_SKIP, PH_XLO, PH_XHI,
        PH_XDATA, PH_NAME, PH_COMMENT, PH_HCRC1, PH_HCRC2, PH_BODY
    } phase_t;

    localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

    phase_t                 phase_reg, phase_next;
    logic                   prev_magic_reg, prev_magic_next;
    logic [2:0]             skip_cnt_reg, skip_cnt_next;
    logic [15:0]            extra_rem_reg, extra_rem_next;
    logic [4:0]             hdr_flags_reg, hdr_flags_next;
    logic [OFFSET_BITS-1:0] member_start_reg, member_start_next;
    logic [OFFSET_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [OFFSET_BITS-1:0] nxt;
    logic                   check_done;
    logic [2:0]             skip_inc;
    logic [15:0]            extra_dec;

    // Next optional-field phase at or after a level
    function automatic phase_t pick_next(input logic [1:0] lvl, input logic [4:0] flags);
        phase_t ph;
        ph = PH_BODY;
        if (lvl <= LVL_HCRC && (flags & FL_HCRC) != 5'd0)
        begin
            ph = PH_HCRC1;
        end
        if (lvl <= LVL_COMMENT && (flags & FL_COMMENT) != 5'd0)
        begin
            ph = PH_COMMENT;
        end
        if (lvl <= LVL_NAME && (flags & FL_NAME) != 5'd0)
        begin
            ph = PH_NAME;
        end
        if (lvl == LVL_EXTRA && (flags & FL_EXTRA) != 5'd0)
        begin
            ph = PH_XLO;
        end
        return ph;
    endfunction

    always_comb
    begin
        phase_next        = phase_reg;
        prev_magic_next   = prev_magic_reg;
        skip_cnt_next     = skip_cnt_reg;
        extra_rem_next    = extra_rem_reg;
        hdr_flags_next    = hdr_flags_reg;
        member_start_next = member_start_reg;
        byte_pos_next     = byte_pos_reg;
        nxt               = byte_pos_reg + OFF_ONE;
        skip_inc          = skip_cnt_reg + 3'd1;
        extra_dec         = extra_rem_reg - 16'd1;
        check_done        = 1'b0;
        res               = '0;

        if (step)
        begin
            case (word.func)
                FUNC_END:
                begin
                    // Report a cut header, then start a fresh stream
                    if (phase_reg >= PH_M2 && phase_reg <= PH_HCRC2)
                    begin
                        res.valid                  = 1'b1;
                        res.word.status            = ST_TRUNC;
                        res.word.flag_bits         = hdr_flags_reg;
                        res.word.member_offset     = 32'(member_start_reg);
                        res.word.header_end_offset = 32'(byte_pos_reg);
                    end
                    phase_next        = PH_M1;
                    prev_magic_next   = 1'b0;
                    skip_cnt_next     = 3'd0;
                    extra_rem_next    = 16'd0;
                    hdr_flags_next    = 5'd0;
                    member_start_next = '0;
                    byte_pos_next     = '0;
                end
                FUNC_BODY_OK, FUNC_BODY_BAD:
                begin
                    if (phase_reg == PH_BODY)
                    begin
                        phase_next      = (word.func == FUNC_BODY_OK) ? PH_M1 : PH_HUNT;
                        prev_magic_next = 1'b0;
                    end
                end
                FUNC_DATA:
                begin
                    byte_pos_next = nxt;
                    case (phase_reg)
                        PH_HUNT:
                        begin
                            if (prev_magic_reg && word.in_byte == MAGIC_B)
                            begin
                                member_start_next = byte_pos_reg - OFF_ONE;
                                hdr_flags_next    = 5'd0;
                                prev_magic_next   = 1'b0;
                                phase_next        = PH_METHOD;
                            end
                            else
                            begin
                                prev_magic_next = (word.in_byte == MAGIC_A);
                            end
                        end
                        PH_M1:
                        begin
                            if (word.in_byte == MAGIC_A)
                            begin
                                member_start_next = byte_pos_reg;
                                hdr_flags_next    = 5'd0;
                                phase_next        = PH_M2;
                            end
                            else
                            begin
                                res.valid                  = 1'b1;
                                res.word.status            = ST_BAD_MAGIC;
                                res.word.member_offset     = 32'(byte_pos_reg);
                                res.word.header_end_offset = 32'(nxt);
                                phase_next                 = PH_HUNT;
                                prev_magic_next            = 1'b0;
                            end
                        end
                        PH_M2:
                        begin
                            if (word.in_byte == MAGIC_B)
                            begin
                                phase_next = PH_METHOD;
                            end
                            else
                            begin
                                res.valid                  = 1'b1;
                                res.word.status            = ST_BAD_MAGIC;
                                res.word.member_offset     = 32'(member_start_reg);
                                res.word.header_end_offset = 32'(nxt);
                                phase_next                 = PH_HUNT;
                                prev_magic_next            = 1'b0;
                            end
                        end
                        PH_METHOD:
                        begin
                            if (word.in_byte == method)
                            begin
                                phase_next = PH_FLAGS;
                            end
                            else
                            begin
                                res.valid                  = 1'b1;
                                res.word.status            = ST_BAD_METH;
                                res.word.member_offset     = 32'(member_start_reg);
                                res.word.header_end_offset = 32'(nxt);
                                phase_next                 = PH_HUNT;
                                prev_magic_next            = 1'b0;
                            end
                        end
                        PH_FLAGS:
                        begin
                            if ((word.in_byte & RES_BITS) != 8'd0)
                            begin
                                res.valid                  = 1'b1;
                                res.word.status            = ST_RESERVED;
                                res.word.flag_bits         = word.in_byte[4:0];
                                res.word.member_offset     = 32'(member_start_reg);
                                res.word.header_end_offset = 32'(nxt);
                                phase_next                 = PH_HUNT;
                                prev_magic_next            = 1'b0;
                            end
                            else
                            begin
                                hdr_flags_next = word.in_byte[4:0];
                                skip_cnt_next  = 3'd0;
                                phase_next     = PH_SKIP;
                            end
                        end
                        PH_SKIP:
                        begin
                            // Drop time, extra flags and OS bytes
                            if (skip_inc < SKIP_LEN)
                            begin
                                skip_cnt_next = skip_inc;
                            end
                            else
                            begin
                                skip_cnt_next = 3'd0;
                                phase_next    = pick_next(LVL_EXTRA, hdr_flags_reg);
                                check_done    = 1'b1;
                            end
                        end
                        PH_XLO:
                        begin
                            extra_rem_next = {8'd0, word.in_byte};
                            phase_next     = PH_XHI;
                        end
                        PH_XHI:
                        begin
                            extra_rem_next = {word.in_byte, extra_rem_reg[7:0]};
                            if ({word.in_byte, extra_rem_reg[7:0]} != 16'd0)
                            begin
                                phase_next = PH_XDATA;
                            end
                            else
                            begin
                                phase_next = pick_next(LVL_NAME, hdr_flags_reg);
                                check_done = 1'b1;
                            end
                        end
                        PH_XDATA:
                        begin
                            extra_rem_next = extra_dec;
                            if (extra_dec == 16'd0)
                            begin
                                phase_next = pick_next(LVL_NAME, hdr_flags_reg);
                                check_done = 1'b1;
                            end
                        end
                        PH_NAME:
                        begin
                            if (word.in_byte == 8'd0)
                            begin
                                phase_next = pick_next(LVL_COMMENT, hdr_flags_reg);
                                check_done = 1'b1;
                            end
                        end
                        PH_COMMENT:
                        begin
                            if (word.in_byte == 8'd0)
                            begin
                                phase_next = pick_next(LVL_HCRC, hdr_flags_reg);
                                check_done = 1'b1;
                            end
                        end
                        PH_HCRC1:
                        begin
                            phase_next = PH_HCRC2;
                        end
                        PH_HCRC2:
                        begin
                            phase_next = PH_BODY;
                            check_done = 1'b1;
                        end
                        default:
                        begin
                            // Body bytes only advance the offset
                        end
                    endcase

                    // Report a completed header
                    if (check_done && phase_next == PH_BODY)
                    begin
                        res.valid                  = 1'b1;
                        res.word.status            = ST_OK;
                        res.word.flag_bits         = hdr_flags_reg;
                        res.word.member_offset     = 32'(member_start_reg);
                        res.word.header_end_offset = 32'(nxt);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_M1;
            prev_magic_reg   <= 1'b0;
            skip_cnt_reg     <= 3'd0;
            extra_rem_reg    <= 16'd0;
            hdr_flags_reg    <= 5'd0;
            member_start_reg <= '0;
            byte_pos_reg     <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            prev_magic_reg   <= prev_magic_next;
            skip_cnt_reg     <= skip_cnt_next;
            extra_rem_reg    <= extra_rem_next;
            hdr_flags_reg    <= hdr_flags_next;
            member_start_reg <= member_start_next;
            byte_pos_reg     <= byte_pos_next;
        end
    end

endmodule

>>> rtl/core/ghs_out_stage.sv
module ghs_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  ghs_pkg::res_t      res,
    output logic               slot_free,
    output logic               out_valid,
    input  logic               out_stall,
    output ghs_pkg::out_word_t out_data
);
    import ghs_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    // A slot is free when empty or being taken this cycle
    assign slot_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (step)
        begin
            valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new report
    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            word_reg <= res.word;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = word_reg;

endmodule

>>> rtl/core/gzip_member_header_scanner.sv
// A result passes the input register, then the result register, before it is presented.
// One word per cycle while the result register can take a report; the parse state updates
// once per word.
// A stalled result blocks new words only once the input register is also full.
// Reset (rst_n, async, active low): strict first-magic phase, offsets zero, method 8.
// The configuration write port is always ready.
module gzip_member_header_scanner #(
    parameter int OFFSET_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ghs_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ghs_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import ghs_pkg::*;

    logic [7:0] meth_reg;
    logic       word_valid;
    in_word_t   word;
    logic       slot_free;
    logic       step;
    res_t       res;

    assign cfg_ready  = 1'b1;

    // Hold the expected method byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meth_reg <= METHOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            meth_reg <= cfg_data;
        end
    end

    assign step = word_valid && slot_free;

    ghs_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .advance    (step),
        .word_valid (word_valid),
        .word       (word)
    );

    ghs_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (word),
        .method (meth_reg),
        .res    (res)
    );

    ghs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A produced report lands in the result register
    a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid |=> out_valid)
        else $error("report lost");

    // Input side stalls only behind a stalled full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");

    // Magic and method errors carry no flags
    a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_BAD_MAGIC || out_data.status == ST_BAD_METH)
        |-> out_data.flag_bits == 5'd0)
        else $error("flags on early error");

endmodule

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ghs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned LONG_HOLD   = 400;

    // Parse phases of the header scanner
    typedef enum logic [3:0] {
        S_HUNT    = 4'd0,
        S_M1      = 4'd1,
        S_M2      = 4'd2,
        S_METHOD  = 4'd3,
        S_FLAGS   = 4'd4,
        S_SKIP    = 4'd5,
        S_XLO     = 4'd6,
        S_XHI     = 4'd7,
        S_XDATA   = 4'd8,
        S_NAME    = 4'd9,
        S_COMMENT = 4'd10,
        S_HCRC1   = 4'd11,
        S_HCRC2   = 4'd12,
        S_BODY    = 4'd13
    } scan_phase_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [7:0] cfg_data = 8'd0;

    // Scanner shadow state
    scan_phase_t scan_phase = S_M1;
    bit          seen_1f    = 1'b0;
    logic [2:0]  skip_cnt   = '0;
    logic [15:0] xlen_left  = '0;
    logic [4:0]  hdr_flags  = '0;
    logic [31:0] member_off = '0;
    logic [31:0] byte_pos   = '0;
    logic [7:0]  cur_method = METHOD_RESET;

    in_word_t  pending_words[$];
    out_word_t reports_due[$];
    out_word_t report_want;

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int unsigned stall_mode = 0;
    bit          hold_req = 1'b0;

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned words_taken = 0;
    int unsigned reports_seen = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned method_writes = 0;

    gzip_member_header_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Queue one expected header report
    function automatic void note_report(logic [2:0] st, logic [4:0] fl,
                                        logic [31:0] first_off, logic [31:0] end_off);
        out_word_t r;
        r.status            = st;
        r.flag_bits         = fl;
        r.member_offset     = first_off;
        r.header_end_offset = end_off;
        reports_due.push_back(r);
    endfunction

    // Return to the strict start-of-stream state
    function automatic void clear_scan();
        scan_phase = S_M1;
        seen_1f    = 1'b0;
        skip_cnt   = '0;
        xlen_left  = '0;
        hdr_flags  = '0;
        member_off = '0;
        byte_pos   = '0;
    endfunction

    // Pick the next optional field at or after the given level
    function automatic scan_phase_t next_field(logic [1:0] lvl);
        if (lvl == LVL_EXTRA && (hdr_flags & FL_EXTRA) != 0)
            return S_XLO;
        if (lvl <= LVL_NAME && (hdr_flags & FL_NAME) != 0)
            return S_NAME;
        if (lvl <= LVL_COMMENT && (hdr_flags & FL_COMMENT) != 0)
            return S_COMMENT;
        if ((hdr_flags & FL_HCRC) != 0)
            return S_HCRC1;
        return S_BODY;
    endfunction

    // Advance the shadow scanner by one accepted word
    function automatic void scan_header_word(in_word_t w);
        logic [31:0] here;
        logic [31:0] after;
        logic [7:0]  b;
        scan_phase_t was;
        here = byte_pos;
        b    = w.in_byte;
        was  = scan_phase;
        if (w.func == FUNC_END)
        begin
            if (scan_phase >= S_M2 && scan_phase <= S_HCRC2)
                note_report(ST_TRUNC, hdr_flags, member_off, byte_pos);
            clear_scan();
            return;
        end
        if (w.func == FUNC_BODY_OK || w.func == FUNC_BODY_BAD)
        begin
            if (scan_phase == S_BODY)
            begin
                if (w.func == FUNC_BODY_OK)
                    scan_phase = S_M1;
                else
                    scan_phase = S_HUNT;
                seen_1f = 1'b0;
            end
            return;
        end
        after    = here + 32'd1;
        byte_pos = after;
        case (scan_phase)
            S_HUNT:
            begin
                if (seen_1f && b == MAGIC_B)
                begin
                    member_off = here - 32'd1;
                    hdr_flags  = '0;
                    seen_1f    = 1'b0;
                    scan_phase = S_METHOD;
                end
                else
                    seen_1f = (b == MAGIC_A);
            end
            S_M1:
            begin
                if (b == MAGIC_A)
                begin
                    member_off = here;
                    hdr_flags  = '0;
                    scan_phase = S_M2;
                end
                else
                begin
                    note_report(ST_BAD_MAGIC, 5'd0, here, after);
                    scan_phase = S_HUNT;
                    seen_1f    = 1'b0;
                end
            end
            S_M2:
            begin
                if (b == MAGIC_B)
                    scan_phase = S_METHOD;
                else
                begin
                    note_report(ST_BAD_MAGIC, 5'd0, member_off, after);
                    scan_phase = S_HUNT;
                    seen_1f    = 1'b0;
                end
            end
            S_METHOD:
            begin
                if (b == cur_method)
                    scan_phase = S_FLAGS;
                else
                begin
                    note_report(ST_BAD_METH, 5'd0, member_off, after);
                    scan_phase = S_HUNT;
                    seen_1f    = 1'b0;
                end
            end
            S_FLAGS:
            begin
                if ((b & RES_BITS) != 0)
                begin
                    note_report(ST_RESERVED, b[4:0], member_off, after);
                    scan_phase = S_HUNT;
                    seen_1f    = 1'b0;
                end
                else
                begin
                    hdr_flags  = b[4:0];
                    skip_cnt   = '0;
                    scan_phase = S_SKIP;
                end
            end
            S_SKIP:
            begin
                skip_cnt = skip_cnt + 3'd1;
                if (skip_cnt >= SKIP_LEN)
                begin
                    skip_cnt   = '0;
                    scan_phase = next_field(LVL_EXTRA);
                end
            end
            S_XLO:
            begin
                xlen_left  = {8'd0, b};
                scan_phase = S_XHI;
            end
            S_XHI:
            begin
                xlen_left = {b, xlen_left[7:0]};
                if (xlen_left != 0)
                    scan_phase = S_XDATA;
                else
                    scan_phase = next_field(LVL_NAME);
            end
            S_XDATA:
            begin
                xlen_left = xlen_left - 16'd1;
                if (xlen_left == 0)
                    scan_phase = next_field(LVL_NAME);
            end
            S_NAME:
            begin
                if (b == 8'd0)
                    scan_phase = next_field(LVL_COMMENT);
            end
            S_COMMENT:
            begin
                if (b == 8'd0)
                    scan_phase = next_field(LVL_HCRC);
            end
            S_HCRC1:
                scan_phase = S_HCRC2;
            S_HCRC2:
                scan_phase = S_BODY;
            default:
            begin
            end
        endcase
        if (was != S_BODY && scan_phase == S_BODY)
            note_report(ST_OK, hdr_flags, member_off, after);
    endfunction

    function automatic in_word_t data_word(logic [7:0] b);
        in_word_t w;
        w.func    = FUNC_DATA;
        w.in_byte = b;
        return w;
    endfunction

    // Non-data events carry a random byte that must be ignored
    function automatic in_word_t event_word(logic [1:0] f);
        in_word_t w;
        w.func    = f;
        w.in_byte = 8'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic put_byte(logic [7:0] b);
        pending_words.push_back(data_word(b));
    endtask

    task automatic put_event(logic [1:0] f);
        pending_words.push_back(event_word(f));
    endtask

    // Queue one member: header, optionally damaged, then a short body unless the header is cut short
    task automatic put_member(logic [4:0] flags, logic [15:0] xlen, bit clean);
        in_word_t    hdr[$];
        int unsigned pick;
        int unsigned n;
        hdr.push_back(data_word(MAGIC_A));
        hdr.push_back(data_word(MAGIC_B));
        hdr.push_back(data_word(cur_method));
        hdr.push_back(data_word({3'b000, flags}));
        repeat (SKIP_LEN) hdr.push_back(data_word(8'($urandom_range(0, 255))));
        if ((flags & FL_EXTRA) != 0)
        begin
            hdr.push_back(data_word(xlen[7:0]));
            hdr.push_back(data_word(xlen[15:8]));
            repeat (xlen) hdr.push_back(data_word(8'($urandom_range(0, 255))));
        end
        if ((flags & FL_NAME) != 0)
        begin
            repeat ($urandom_range(0, 5)) hdr.push_back(data_word(8'($urandom_range(1, 255))));
            hdr.push_back(data_word(8'd0));
        end
        if ((flags & FL_COMMENT) != 0)
        begin
            repeat ($urandom_range(0, 5)) hdr.push_back(data_word(8'($urandom_range(1, 255))));
            hdr.push_back(data_word(8'd0));
        end
        if ((flags & FL_HCRC) != 0)
            repeat (2) hdr.push_back(data_word(8'($urandom_range(0, 255))));

        // Damage some headers: cut short, bad magic or method, reserved flags
        pick = $urandom_range(0, 99);
        if (!clean && pick < 10)
        begin
            n   = $urandom_range(1, hdr.size() - 1);
            hdr = hdr[0:n-1];
            hdr.push_back(event_word(FUNC_END));
        end
        else if (!clean && pick < 16)
            hdr[$urandom_range(0, 2)].in_byte = 8'($urandom_range(0, 255));
        else if (!clean && pick < 22)
            hdr[3].in_byte[7:5] = 3'($urandom_range(1, 7));
        foreach (hdr[i])
            pending_words.push_back(hdr[i]);
        if (!clean && pick < 10)
            return;

        repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            put_event(FUNC_BODY_OK);
        else if (pick < 9)
            put_event(FUNC_BODY_BAD);
        else
            put_event(FUNC_END);
    endtask

    // Queue a random mix of members, noise and stray events
    task automatic put_stream(int unsigned count);
        int unsigned start;
        int unsigned pick;
        logic [15:0] xl;
        start = pending_words.size();
        while (pending_words.size() - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                xl = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
                if ($urandom_range(0, 49) == 0)
                    xl = 16'($urandom_range(256, 300));
                put_member(5'($urandom_range(0, 31)), xl, 1'b0);
            end
            else if (pick < 88)
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
            else if (pick < 93)
                put_event(FUNC_END);
            else if (pick < 97)
                put_event(FUNC_BODY_OK);
            else
                put_event(FUNC_BODY_BAD);
        end
    endtask

    // Write the method register and track it in the shadow copy
    task automatic write_method(logic [7:0] m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_method = m;
        method_writes++;
        @(negedge clk);
    endtask

    // Wait until every word is in and every report is out, then let the pipe empty
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_words.size() != 0 || in_valid || reports_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Sender: bursts of words with random gaps, hold the word while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                scan_header_word(in_data);
                words_taken++;
            end
            if (in_valid && in_stall)
                input_stall_cycles++;
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_words.pop_front();
                if (burst_left == 0)
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 16);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall in stretches of changing density, or one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_left  = 0;
            mode_left  = 0;
            stall_mode = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 120);
                end
                else
                    mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // Compare each accepted report against the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            reports_seen++;
            if (reports_due.size() == 0)
            begin
                $error("unexpected report: status %0d at offset %0d",
                       out_data.status, out_data.member_offset);
                fail_count++;
            end
            else
            begin
                report_want = reports_due.pop_front();
                if (out_data.status !== report_want.status)
                begin
                    $error("status: expected %0d, got %0d",
                           report_want.status, out_data.status);
                    fail_count++;
                end
                if (out_data.flag_bits !== report_want.flag_bits)
                begin
                    $error("flag_bits: expected 0x%02h, got 0x%02h",
                           report_want.flag_bits, out_data.flag_bits);
                    fail_count++;
                end
                if (out_data.member_offset !== report_want.member_offset)
                begin
                    $error("member_offset: expected %0d, got %0d",
                           report_want.member_offset, out_data.member_offset);
                    fail_count++;
                end
                if (out_data.header_end_offset !== report_want.header_end_offset)
                begin
                    $error("header_end_offset: expected %0d, got %0d",
                           report_want.header_end_offset, out_data.header_end_offset);
                    fail_count++;
                end
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("gzip_member_header_scanner verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: error kinds, stray events, truncation, empty extra field
        put_byte(8'h00);
        put_event(FUNC_END);
        put_byte(MAGIC_A);
        put_byte(8'h00);
        put_byte(MAGIC_A);
        put_byte(MAGIC_B);
        put_byte(8'h07);
        put_byte(MAGIC_A);
        put_byte(MAGIC_B);
        put_byte(METHOD_RESET);
        put_byte(8'hff);
        put_event(FUNC_END);
        put_event(FUNC_BODY_OK);
        put_byte(MAGIC_A);
        put_event(FUNC_END);
        put_byte(MAGIC_A);
        put_byte(MAGIC_B);
        put_byte(METHOD_RESET);
        put_byte({3'b000, FL_EXTRA});
        repeat (3)
        begin
            put_byte(8'hff);
            put_byte(8'h00);
        end
        put_byte(8'h00);
        put_byte(8'h00);
        put_event(FUNC_BODY_BAD);
        wait_drained();

        // Method register at both extremes
        write_method(8'h00);
        put_stream(200);
        wait_drained();
        write_method(8'hff);
        put_stream(200);
        wait_drained();

        // Long receiver hold-off over a run of short error reports
        write_method(8'($urandom_range(1, 254)));
        hold_req = 1'b1;
        repeat (30)
        begin
            put_byte(8'($urandom_range(0, 30)));
            put_event(FUNC_END);
        end
        put_stream(200);
        wait_drained();

        // Back to the default method, one member with a long extra field
        write_method(METHOD_RESET);
        put_member(FL_EXTRA | FL_NAME, 16'h0102, 1'b1);
        put_stream(200);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("run covered %0d stream words and %0d header reports over %0d method settings",
                 words_taken, reports_seen, method_writes + 1);
        $display("input held off for %0d cycles while reports backed up", input_stall_cycles);
        if (fail_count == 0)
            $display("gzip_member_header_scanner verification clean");
        else
            $display("gzip_member_header_scanner verification failed");
        $finish;
    end

endmodule
